// ===== rtl/bilinear_image_scaler_macros.svh =====
// Assertion helpers, clocked on clk_i and disabled while rst_ni is low.
`ifndef BILINEAR_IMAGE_SCALER_MACROS_SVH
`define BILINEAR_IMAGE_SCALER_MACROS_SVH

// Same-cycle implication.
`define BIS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BIS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/bis_pkg.sv =====
package bis_pkg;

  localparam int unsigned MaxSrcWidthDef  = 256;
  localparam int unsigned MaxSrcHeightDef = 256;
  localparam int unsigned FracBitsDef     = 16;

  localparam int unsigned SrcSizeW  = 9;   // source_width / source_height
  localparam int unsigned DstSizeW  = 13;  // target_width / target_height
  localparam int unsigned CfgDataW  = 13;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned LdCoordW  = 8;
  localparam int unsigned DstCoordW = 12;
  localparam int unsigned PixW      = 24;
  localparam int unsigned OutPixW   = 32;
  localparam int unsigned ChanW     = 8;
  localparam int unsigned NumChan   = 3;

  localparam int unsigned CfgSizeRst = 256;

  localparam logic [ChanW-1:0] AlphaByte = 8'hff;

  typedef enum logic [CfgIdxW-1:0] {
    CfgSrcWidth  = 2'd0,
    CfgSrcHeight = 2'd1,
    CfgDstWidth  = 2'd2,
    CfgDstHeight = 2'd3
  } cfg_idx_e;

endpackage

// ===== rtl/bis_src_bank.sv =====
module bis_src_bank
  import bis_pkg::*;
#(
  parameter int unsigned ADDR_W = 14
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [PixW-1:0]   wdata_i,
  output logic [PixW-1:0]   rdata_o
);

  logic [PixW-1:0] mem [2**ADDR_W];
  logic [PixW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/bis_ratio_div.sv =====
module bis_ratio_div
  import bis_pkg::*;
#(
  parameter int unsigned NUM_W         = 8,
  parameter int unsigned FRACTION_BITS = 16,
  parameter int unsigned RATIO_W       = NUM_W + FRACTION_BITS,
  parameter logic [RATIO_W-1:0] COL_RST = '0,
  parameter logic [RATIO_W-1:0] ROW_RST = '0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [NUM_W-1:0]    col_num_i,
  input  logic [NUM_W-1:0]    row_num_i,
  input  logic [DstSizeW-1:0] col_den_i,
  input  logic [DstSizeW-1:0] row_den_i,
  output logic                busy_o,
  output logic [RATIO_W-1:0]  col_ratio_o,
  output logic [RATIO_W-1:0]  row_ratio_o
);

  localparam int unsigned CntW = $clog2(RATIO_W);
  localparam logic [CntW-1:0] LastStep = CntW'(RATIO_W - 1);

  typedef enum logic [1:0] {
    DvIdle,
    DvCol,
    DvRow
  } dv_state_e;

  dv_state_e           state_q;
  logic [CntW-1:0]     cnt_q;
  logic [DstSizeW-1:0] rem_q;
  logic [DstSizeW-1:0] den_q;
  logic [RATIO_W-1:0]  quo_q;
  logic [RATIO_W-1:0]  col_ratio_q;
  logic [RATIO_W-1:0]  row_ratio_q;

  logic [DstSizeW:0]   trial;
  logic                qbit;
  logic [DstSizeW-1:0] rem_d;
  logic [RATIO_W-1:0]  quo_d;

  // one restoring step: remainder shifts in the next dividend bit
  always_comb begin
    trial = {rem_q, quo_q[RATIO_W-1]};
    qbit  = (trial >= {1'b0, den_q});
    rem_d = qbit ? DstSizeW'(trial - {1'b0, den_q}) : DstSizeW'(trial);
    quo_d = {quo_q[RATIO_W-2:0], qbit};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= DvIdle;
      cnt_q       <= '0;
      rem_q       <= '0;
      den_q       <= '0;
      quo_q       <= '0;
      col_ratio_q <= COL_RST;
      row_ratio_q <= ROW_RST;
    end else if (start_i) begin
      state_q <= DvCol;
      cnt_q   <= '0;
      rem_q   <= '0;
      den_q   <= col_den_i;
      quo_q   <= RATIO_W'(col_num_i) << FRACTION_BITS;
    end else begin
      unique case (state_q)
        DvIdle: begin
          state_q <= DvIdle;
        end
        DvCol: begin
          if (cnt_q == LastStep) begin
            col_ratio_q <= quo_d;
            state_q     <= DvRow;
            cnt_q       <= '0;
            rem_q       <= '0;
            den_q       <= row_den_i;
            quo_q       <= RATIO_W'(row_num_i) << FRACTION_BITS;
          end else begin
            cnt_q <= cnt_q + 1'b1;
            rem_q <= rem_d;
            quo_q <= quo_d;
          end
        end
        DvRow: begin
          if (cnt_q == LastStep) begin
            row_ratio_q <= quo_d;
            state_q     <= DvIdle;
          end else begin
            cnt_q <= cnt_q + 1'b1;
            rem_q <= rem_d;
            quo_q <= quo_d;
          end
        end
        default: begin
          state_q <= DvIdle;
        end
      endcase
    end
  end

  assign busy_o      = (state_q != DvIdle);
  assign col_ratio_o = col_ratio_q;
  assign row_ratio_o = row_ratio_q;

endmodule

// ===== rtl/bilinear_image_scaler.sv =====
// Pipeline: five register stages, S1 to S5; a compute word's result is valid once it
// reaches the S5 output register. Load words leave the pipe after the store write.
// Throughput: one word per cycle when not stalled; load and compute words mix freely.
// A configuration write recomputes both step ratios in a shared restoring divider,
// one quotient bit a cycle: the new sizes are registered, a start strobe follows, then
// the divider forms the column ratio and then the row ratio, input stalled throughout.
// Reset: async active low; pipeline empties, config returns to 256, ratios preset.
`include "bilinear_image_scaler_macros.svh"

module bilinear_image_scaler
  import bis_pkg::*;
#(
  parameter int unsigned MAX_SOURCE_WIDTH  = MaxSrcWidthDef,
  parameter int unsigned MAX_SOURCE_HEIGHT = MaxSrcHeightDef,
  parameter int unsigned FRACTION_BITS     = FracBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write port
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  // input words
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 command_i,
  input  logic [PixW-1:0]      source_pixel_i,
  input  logic [LdCoordW-1:0]  source_col_i,
  input  logic [LdCoordW-1:0]  source_row_i,
  input  logic [DstCoordW-1:0] target_col_i,
  input  logic [DstCoordW-1:0] target_row_i,
  // result words
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [OutPixW-1:0]   scaled_pixel_o
);

  // Coordinate widths of the store; each store dimension is split in two by parity.
  localparam int unsigned ColW    = (MAX_SOURCE_WIDTH > 1) ? $clog2(MAX_SOURCE_WIDTH) : 1;
  localparam int unsigned RowW    = (MAX_SOURCE_HEIGHT > 1) ? $clog2(MAX_SOURCE_HEIGHT) : 1;
  localparam int unsigned NumW    = (ColW > RowW) ? ColW : RowW;
  localparam int unsigned HColW   = (ColW > 1) ? ColW - 1 : 1;
  localparam int unsigned HRowW   = (RowW > 1) ? RowW - 1 : 1;
  localparam int unsigned BankAw  = HColW + HRowW;
  localparam int unsigned RatioW  = NumW + FRACTION_BITS;
  localparam int unsigned PosW    = RatioW + DstCoordW;
  localparam int unsigned IntW    = PosW - FRACTION_BITS;
  localparam int unsigned WgtW    = 2 * FRACTION_BITS + 1;
  localparam int unsigned ProdW   = WgtW + ChanW;
  localparam int unsigned SumW    = ProdW + 2;
  localparam int unsigned NumBank = 4;

  // Ratios after reset, from the reset sizes.
  localparam longint unsigned SwEffRst =
    (CfgSizeRst > MAX_SOURCE_WIDTH) ? MAX_SOURCE_WIDTH : CfgSizeRst;
  localparam longint unsigned ShEffRst =
    (CfgSizeRst > MAX_SOURCE_HEIGHT) ? MAX_SOURCE_HEIGHT : CfgSizeRst;
  localparam longint unsigned ColRatioRst = ((SwEffRst - 1) << FRACTION_BITS) / CfgSizeRst;
  localparam longint unsigned RowRatioRst = ((ShEffRst - 1) << FRACTION_BITS) / CfgSizeRst;

  localparam logic [FRACTION_BITS:0] One    = {1'b1, {FRACTION_BITS{1'b0}}};
  localparam logic [WgtW+1:0]        OneSq  = (WgtW+2)'(1) << (2 * FRACTION_BITS);

  // ---------------------------------------------------------------------------
  // Configuration registers and derived clamps
  // ---------------------------------------------------------------------------
  logic [SrcSizeW-1:0] src_w_q, src_h_q;
  logic [DstSizeW-1:0] dst_w_q, dst_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= SrcSizeW'(CfgSizeRst);
      src_h_q <= SrcSizeW'(CfgSizeRst);
      dst_w_q <= DstSizeW'(CfgSizeRst);
      dst_h_q <= DstSizeW'(CfgSizeRst);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgSrcWidth:  src_w_q <= SrcSizeW'(cfg_data_i);
        CfgSrcHeight: src_h_q <= SrcSizeW'(cfg_data_i);
        CfgDstWidth:  dst_w_q <= cfg_data_i;
        CfgDstHeight: dst_h_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // last usable column / row: size saturated to 1..max, minus one
  logic [NumW-1:0]     wm1, hm1;
  logic [DstSizeW-1:0] dst_w_eff, dst_h_eff;

  always_comb begin
    if (src_w_q == '0) begin
      wm1 = '0;
    end else if (int'(src_w_q) > MAX_SOURCE_WIDTH) begin
      wm1 = NumW'(MAX_SOURCE_WIDTH - 1);
    end else begin
      wm1 = NumW'(src_w_q - 1'b1);
    end
    if (src_h_q == '0) begin
      hm1 = '0;
    end else if (int'(src_h_q) > MAX_SOURCE_HEIGHT) begin
      hm1 = NumW'(MAX_SOURCE_HEIGHT - 1);
    end else begin
      hm1 = NumW'(src_h_q - 1'b1);
    end
    dst_w_eff = (dst_w_q == '0) ? DstSizeW'(1) : dst_w_q;
    dst_h_eff = (dst_h_q == '0) ? DstSizeW'(1) : dst_h_q;
  end

  // ---------------------------------------------------------------------------
  // Step ratio divider; it starts the cycle after a write, once the sizes settle
  // ---------------------------------------------------------------------------
  logic              cfg_start_q;
  logic              div_busy;
  logic [RatioW-1:0] col_ratio, row_ratio;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_start_q <= 1'b0;
    end else begin
      cfg_start_q <= cfg_we_i;
    end
  end

  bis_ratio_div #(
    .NUM_W         (NumW),
    .FRACTION_BITS (FRACTION_BITS),
    .RATIO_W       (RatioW),
    .COL_RST       (RatioW'(ColRatioRst)),
    .ROW_RST       (RatioW'(RowRatioRst))
  ) u_ratio_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cfg_start_q),
    .col_num_i   (wm1),
    .row_num_i   (hm1),
    .col_den_i   (dst_w_eff),
    .row_den_i   (dst_h_eff),
    .busy_o      (div_busy),
    .col_ratio_o (col_ratio),
    .row_ratio_o (row_ratio)
  );

  // ---------------------------------------------------------------------------
  // Pipeline flow control: a stage loads when empty or when the next one moves,
  // so bubbles collapse behind a stalled output.
  // ---------------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic en1, en2, en3, en4, en5;
  logic in_take;

  assign en5        = !v5_q || !out_stall_i;
  assign en4        = !v4_q || en5;
  assign en3        = !v3_q || en4;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_stall_o = !en1 || div_busy || cfg_start_q;
  assign in_take    = in_valid_i && !in_stall_o;

  // ---------------------------------------------------------------------------
  // S1: source position = ratio * coordinate
  // ---------------------------------------------------------------------------
  logic                cmd1_q;
  logic [PixW-1:0]     pix1_q;
  logic [LdCoordW-1:0] lcol1_q, lrow1_q;
  logic [PosW-1:0]     px1_q, py1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en1) begin
      v1_q <= in_take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      cmd1_q  <= command_i;
      pix1_q  <= source_pixel_i;
      lcol1_q <= source_col_i;
      lrow1_q <= source_row_i;
      px1_q   <= PosW'(col_ratio) * PosW'(target_col_i);
      py1_q   <= PosW'(row_ratio) * PosW'(target_row_i);
    end
  end

  // ---------------------------------------------------------------------------
  // S2: neighbor coordinates, clamp, bank addressing (load or read)
  // ---------------------------------------------------------------------------
  logic [IntW-1:0]   xint, yint;
  logic [NumW-1:0]   x0, x1, y0, y1;
  logic [NumW-1:0]   ccol [2];
  logic [NumW-1:0]   crow [2];
  logic [NumW-1:0]   lcol, lrow;
  logic              ld_ok;
  logic [BankAw-1:0] addr_d [NumBank];
  logic              we_d   [NumBank];

  logic                     cmd2_q;
  logic [PixW-1:0]          pix2_q;
  logic [BankAw-1:0]        addr2_q [NumBank];
  logic                     we2_q   [NumBank];
  logic [FRACTION_BITS-1:0] fx2_q, fy2_q;
  logic                     ax2_q, bx2_q, ay2_q, cy2_q;

  always_comb begin
    xint = IntW'(px1_q >> FRACTION_BITS);
    yint = IntW'(py1_q >> FRACTION_BITS);
    x0   = (xint > IntW'(wm1)) ? wm1 : NumW'(xint);
    y0   = (yint > IntW'(hm1)) ? hm1 : NumW'(yint);
    x1   = (x0 == wm1) ? x0 : NumW'(x0 + 1'b1);
    y1   = (y0 == hm1) ? y0 : NumW'(y0 + 1'b1);
    // the column of each parity among the two neighbor columns
    ccol[0] = (x0[0] == 1'b0) ? x0 : x1;
    ccol[1] = (x0[0] == 1'b1) ? x0 : x1;
    crow[0] = (y0[0] == 1'b0) ? y0 : y1;
    crow[1] = (y0[0] == 1'b1) ? y0 : y1;
    lcol  = NumW'(lcol1_q);
    lrow  = NumW'(lrow1_q);
    ld_ok = (int'(lcol1_q) < MAX_SOURCE_WIDTH) && (int'(lrow1_q) < MAX_SOURCE_HEIGHT);
    for (int b = 0; b < NumBank; b++) begin
      if (cmd1_q) begin
        addr_d[b] = {HRowW'(crow[b/2] >> 1), HColW'(ccol[b%2] >> 1)};
        we_d[b]   = 1'b0;
      end else begin
        addr_d[b] = {HRowW'(lrow >> 1), HColW'(lcol >> 1)};
        we_d[b]   = ld_ok && (lcol[0] == 1'((b % 2))) && (lrow[0] == 1'((b / 2)));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      cmd2_q  <= cmd1_q;
      pix2_q  <= pix1_q;
      addr2_q <= addr_d;
      we2_q   <= we_d;
      fx2_q   <= px1_q[FRACTION_BITS-1:0];
      fy2_q   <= py1_q[FRACTION_BITS-1:0];
      // bank parities of the four neighbors; a clamped neighbor reuses its partner
      ax2_q   <= x0[0];
      bx2_q   <= (x1 == x0) ? x0[0] : x1[0];
      ay2_q   <= y0[0];
      cy2_q   <= (y1 == y0) ? y0[0] : y1[0];
    end
  end

  // ---------------------------------------------------------------------------
  // S3: four parity banks read (or at most one written), blend weights formed
  // ---------------------------------------------------------------------------
  logic [PixW-1:0] rd [NumBank];

  for (genvar b = 0; b < NumBank; b++) begin : g_bank
    bis_src_bank #(
      .ADDR_W (BankAw)
    ) u_bank (
      .clk_i   (clk_i),
      .en_i    (en3),
      .we_i    (v2_q && we2_q[b]),
      .addr_i  (addr2_q[b]),
      .wdata_i (pix2_q),
      .rdata_o (rd[b])
    );
  end

  logic [FRACTION_BITS:0] omfx, omfy;
  logic                   cmd3_q;
  logic [WgtW-1:0]        wa3_q, wb3_q, wc3_q, wd3_q;
  logic                   ax3_q, bx3_q, ay3_q, cy3_q;

  assign omfx = One - {1'b0, fx2_q};
  assign omfy = One - {1'b0, fy2_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en3) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      cmd3_q <= cmd2_q;
      wa3_q  <= WgtW'(omfx) * WgtW'(omfy);
      wb3_q  <= WgtW'(fx2_q) * WgtW'(omfy);
      wc3_q  <= WgtW'(omfx) * WgtW'(fy2_q);
      wd3_q  <= WgtW'(fx2_q) * WgtW'(fy2_q);
      ax3_q  <= ax2_q;
      bx3_q  <= bx2_q;
      ay3_q  <= ay2_q;
      cy3_q  <= cy2_q;
    end
  end

  // ---------------------------------------------------------------------------
  // S4: per-channel weighted products; load words drop out here
  // ---------------------------------------------------------------------------
  logic [PixW-1:0]  pa, pb, pc, pd;
  logic [ProdW-1:0] prod4_q [NumChan][4];

  always_comb begin
    pa = rd[{ay3_q, ax3_q}];
    pb = rd[{ay3_q, bx3_q}];
    pc = rd[{cy3_q, ax3_q}];
    pd = rd[{cy3_q, bx3_q}];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en4) begin
      v4_q <= v3_q && cmd3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      for (int c = 0; c < NumChan; c++) begin
        prod4_q[c][0] <= ProdW'(pa[c*ChanW +: ChanW]) * ProdW'(wa3_q);
        prod4_q[c][1] <= ProdW'(pb[c*ChanW +: ChanW]) * ProdW'(wb3_q);
        prod4_q[c][2] <= ProdW'(pc[c*ChanW +: ChanW]) * ProdW'(wc3_q);
        prod4_q[c][3] <= ProdW'(pd[c*ChanW +: ChanW]) * ProdW'(wd3_q);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // S5: sum, truncate, pack with opaque alpha into the output register
  // ---------------------------------------------------------------------------
  logic [SumW-1:0]    csum [NumChan];
  logic [PixW-1:0]    rgb;
  logic [OutPixW-1:0] out_q;

  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      csum[c] = SumW'(prod4_q[c][0]) + SumW'(prod4_q[c][1])
              + SumW'(prod4_q[c][2]) + SumW'(prod4_q[c][3]);
      rgb[c*ChanW +: ChanW] = ChanW'(csum[c] >> (2 * FRACTION_BITS));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (en5) begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en5) begin
      out_q <= {AlphaByte, rgb};
    end
  end

  assign out_valid_o    = v5_q;
  assign scaled_pixel_o = out_q;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  logic [WgtW+1:0] wsum_chk;

  assign wsum_chk = (WgtW+2)'(wa3_q) + (WgtW+2)'(wb3_q) + (WgtW+2)'(wc3_q)
                  + (WgtW+2)'(wd3_q);

  `BIS_ASSERT_NOW(a_busy_stalls, div_busy, in_stall_o, "input taken during ratio update")
  `BIS_ASSERT_NXT(a_cmp_enters, in_valid_i && !in_stall_o && command_i, v1_q && cmd1_q,
                  "accepted compute word lost at stage 1")
  `BIS_ASSERT_NOW(a_wgt_unity, v3_q && cmd3_q, wsum_chk == OneSq,
                  "blend weights do not sum to one")
  `BIS_ASSERT_NOW(a_alpha, out_valid_o, scaled_pixel_o[OutPixW-1 -: ChanW] == AlphaByte,
                  "alpha not opaque")

endmodule
